// File: rtl/pth_pkg.sv
// ----------------------------------------------------------------------------
// pth_pkg
// Shared constants and helper functions for the popcount tuple histogram.
// ----------------------------------------------------------------------------
package pth_pkg;

	localparam int COUNT_WIDTH = 64;           // width of a bin and of the tally total
	localparam int BIN_BITS    = 20;
	localparam int NUM_BINS    = 1 << BIN_BITS;
	localparam int NIB_W       = 4;
	localparam int WIN_DEPTH   = 4;
	localparam int FILL_W      = 3;
	localparam int WORD_W      = 32;
	localparam int FIELD_W     = 64;           // width of the count fields on the port

	localparam int IN_TDATA_W  = 56;           // sample_word, bin_index, padded to bytes
	localparam int OUT_TDATA_W = 152;          // bin_count, tally_bin, total_tallies

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [BIN_BITS-1:0]    bin_t;
	typedef logic [NIB_W-1:0]       nib_t;

	typedef enum logic {
		ACT_TALLY = 1'b0,
		ACT_READ  = 1'b1
	} action_t;

	// Set-bit count by a tree of pairwise adds.
	function automatic logic [5:0] ones_in(input logic [WORD_W-1:0] word);
		logic [WORD_W-1:0] v;
		v = word;
		v = (v & 32'h5555_5555) + ((v >> 1)  & 32'h5555_5555);
		v = (v & 32'h3333_3333) + ((v >> 2)  & 32'h3333_3333);
		v = (v & 32'h0f0f_0f0f) + ((v >> 4)  & 32'h0f0f_0f0f);
		v = (v & 32'h00ff_00ff) + ((v >> 8)  & 32'h00ff_00ff);
		v = (v & 32'h0000_ffff) + ((v >> 16) & 32'h0000_ffff);
		return v[5:0];
	endfunction

	// Upper two bits of every nibble go to the top half, lower two bits to the bottom.
	function automatic bin_t scatter_index(input bin_t w);
		bin_t hi;
		bin_t lo;
		hi = (w & 20'h000cc) | ((w & 20'hccc00) >> 10);
		lo = (w & 20'h00333) | ((w & 20'h33000) >> 10);
		return lo | (hi << 10);
	endfunction

	function automatic count_t sat_inc(input count_t v);
		return (v == '1) ? v : v + count_t'(1);
	endfunction

endpackage

// File: rtl/popcount_tuple_histogram.sv
// ----------------------------------------------------------------------------
// popcount_tuple_histogram
// Count-the-ones histogram over overlapping five-word windows, with bin read.
// ----------------------------------------------------------------------------
// Each item is either a tally of one 32-bit sample or a read of one bin, and
// gives one result. From acceptance to result an item goes through these
// steps: register the window and bin address, read the bin memory, then
// increment, write back and load the output register. After reset the block
// sweeps the bin memory (2^20 entries) to zero, one bin per cycle, before
// tready first rises. A result waiting on the output does not block
// acceptance of the next item; it only holds the update step until it is
// taken.
module popcount_tuple_histogram (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [31:0] sample_word, [51:32] bin_index, [55:52] zero
	input  logic [pth_pkg::IN_TDATA_W-1:0]     s_tdata,
	// [0] action
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [63:0] bin_count, [83:64] tally_bin, [147:84] total_tallies, [151:148] zero
	output logic [pth_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// [0] tallied
	output logic                               m_tuser
);
	import pth_pkg::*;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_UPDATE
	} state_t;

	state_t  state_q;
	bin_t    clr_q;
	nib_t    window_q [WIN_DEPTH];
	logic [FILL_W-1:0] fill_q;
	count_t  total_q;

	logic    read_q;
	logic    tally_q;
	bin_t    addr_q;
	count_t  rd_q;

	logic    out_valid_q;
	logic [FIELD_W-1:0] out_count_q;
	bin_t    out_bin_q;
	logic [FIELD_W-1:0] out_total_q;
	logic    out_tallied_q;

	count_t  bin_mem [NUM_BINS];

	logic    in_fire;
	logic    upd_fire;
	action_t in_action;
	logic [WORD_W-1:0] in_word;
	bin_t    in_index;
	logic [5:0] ones;
	nib_t    nib;
	logic    full;
	bin_t    hit;
	count_t  bin_next;
	logic    mem_we;
	bin_t    mem_wa;
	count_t  mem_wd;

	assign in_action = action_t'(s_tuser);
	assign in_word   = s_tdata[WORD_W-1:0];
	assign in_index  = s_tdata[WORD_W +: BIN_BITS];

	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign upd_fire = (state_q == ST_UPDATE) && (!out_valid_q || m_tready);

	assign ones = ones_in(in_word);
	assign nib  = ones[NIB_W:1];
	assign full = (fill_q == FILL_W'(WIN_DEPTH));
	assign hit  = scatter_index({nib, window_q[3], window_q[2], window_q[1], window_q[0]});

	assign bin_next = sat_inc(rd_q);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = addr_q;
		mem_wd = bin_next;
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
			mem_wd = '0;
		end else if (upd_fire && tally_q) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			bin_mem[mem_wa] <= mem_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOOK) begin
			rd_q <= bin_mem[addr_q];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			addr_q <= (in_action == ACT_READ) ? in_index : hit;
		end
		if (upd_fire) begin
			out_count_q   <= read_q ? FIELD_W'(rd_q) : '0;
			out_bin_q     <= tally_q ? addr_q : '0;
			out_total_q   <= FIELD_W'(tally_q ? sat_inc(total_q) : total_q);
			out_tallied_q <= tally_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			fill_q      <= '0;
			total_q     <= '0;
			read_q      <= 1'b0;
			tally_q     <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < WIN_DEPTH; i++) begin
				window_q[i] <= '0;
			end
		end else begin
			if (upd_fire) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + bin_t'(1);
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						read_q  <= (in_action == ACT_READ);
						tally_q <= (in_action == ACT_TALLY) && full;
						if (in_action == ACT_TALLY) begin
							if (full) begin
								window_q[0] <= window_q[1];
								window_q[1] <= window_q[2];
								window_q[2] <= window_q[3];
								window_q[3] <= nib;
							end else begin
								window_q[fill_q[1:0]] <= nib;
								fill_q <= fill_q + FILL_W'(1);
							end
						end
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					// hold until the output register is free
					if (upd_fire) begin
						if (tally_q) begin
							total_q <= sat_inc(total_q);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_tallied_q;
	assign m_tdata  = {4'b0, out_total_q, out_bin_q, out_count_q};

endmodule

// File: test/popcount_tuple_histogram_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// popcount_tuple_histogram_test
// Self-checking bench for the count-the-ones histogram. A local model keeps
// the four stored window nibbles, the bin counts and the tally total, and
// predicts every reply. Directed windows and read-backs come first, then a
// random mix of tallies and reads, mostly with random idling on both sides.
// ----------------------------------------------------------------------------
module popcount_tuple_histogram_test;
	import pth_pkg::*;

	typedef struct {
		count_t bin_count;
		logic   tallied;
		bin_t   tally_bin;
		count_t total_tallies;
	} hist_reply_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_tvalid = 1'b0;
	logic                    s_tready;
	logic [IN_TDATA_W-1:0]   s_tdata = '0;
	logic                    s_tuser = 1'b0;
	logic                    m_tvalid;
	logic                    m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0]  m_tdata;
	logic                    m_tuser;

	// model state
	nib_t        win_nib [WIN_DEPTH];
	int unsigned win_fill;
	count_t      bin_tally [bin_t];
	count_t      tally_count;

	hist_reply_t replies_q [$];
	bin_t        hit_log [$];
	bit          sender_idle_on = 1'b1;
	bit          sink_stall_on = 1'b1;
	int          errors = 0;

	popcount_tuple_histogram u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #4 clk = ~clk;

	function automatic count_t count_bump(input count_t v);
		if (~&v)
			v = v + 1;
		return v;
	endfunction

	// Predict the reply to one transfer and update the model.
	function automatic hist_reply_t histogram_step(input action_t act,
			input logic [WORD_W-1:0] word, input bin_t idx);
		hist_reply_t r;
		logic [5:0]  ones;
		nib_t        nib;
		bin_t        hit;
		r.bin_count = '0;
		r.tallied   = 1'b0;
		r.tally_bin = '0;
		if (act == ACT_READ) begin
			r.bin_count = bin_tally.exists(idx) ? bin_tally[idx] : count_t'(0);
		end else begin
			ones = 6'($countones(word));
			nib  = ones[4:1];          // a full word of 32 wraps to zero
			if (win_fill >= WIN_DEPTH) begin
				// upper pairs of all five nibbles on top, lower pairs below
				hit = {nib[3:2], win_nib[1][3:2], win_nib[3][3:2], win_nib[0][3:2],
					win_nib[2][3:2], win_nib[2][1:0], nib[1:0], win_nib[1][1:0],
					win_nib[3][1:0], win_nib[0][1:0]};
				bin_tally[hit] = count_bump(bin_tally.exists(hit) ? bin_tally[hit]
					: count_t'(0));
				tally_count = count_bump(tally_count);
				r.tallied   = 1'b1;
				r.tally_bin = hit;
				hit_log.push_back(hit);
				if (hit_log.size() > 64)
					void'(hit_log.pop_front());
				win_nib[0] = win_nib[1];
				win_nib[1] = win_nib[2];
				win_nib[2] = win_nib[3];
				win_nib[3] = nib;
			end else begin
				win_nib[win_fill] = nib;
				win_fill++;
			end
		end
		r.total_tallies = tally_count;
		return r;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [WORD_W-1:0] word_with_ones(input int unsigned k);
		logic [WORD_W-1:0] w;
		int unsigned       pos;
		w = (k > 16) ? '1 : '0;
		while ($countones(w) != k) begin
			pos    = $urandom_range(WORD_W - 1);
			w[pos] = (k <= 16);
		end
		return w;
	endfunction

	task automatic send_item(input action_t act, input logic [WORD_W-1:0] word,
			input bin_t idx);
		int unsigned gap;
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {4'b0, idx, word};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		replies_q.push_back(histogram_step(act, word, idx));
		gap = sender_idle_on ? pick_gap() : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold the sender until every pending reply has been taken.
	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (replies_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_window_fill();
		send_item(ACT_READ,  '0, '0);
		send_item(ACT_TALLY, 32'h0000_0000, '0);
		send_item(ACT_READ,  '0, 20'hFFFFF);
		send_item(ACT_TALLY, 32'hFFFF_FFFF, '0);
		send_item(ACT_TALLY, 32'h7FFF_FFFF, '0);
		send_item(ACT_READ,  '0, '0);
		send_item(ACT_TALLY, 32'h0000_0003, '0);
		send_item(ACT_TALLY, 32'hFFFF_FFFE, '0);
	endtask

	task automatic test_extreme_words();
		send_item(ACT_TALLY, 32'h8000_0000, 20'hFFFFF);
		send_item(ACT_TALLY, 32'hFFFF_0000, 20'hFFFFF);
		send_item(ACT_TALLY, 32'h0000_FFFF, '0);
		send_item(ACT_TALLY, 32'hAAAA_AAAA, '0);
		send_item(ACT_TALLY, 32'h5555_5555, '0);
		// five full words leave an all-zero window
		repeat (5) send_item(ACT_TALLY, 32'hFFFF_FFFF, '0);
	endtask

	task automatic test_readback_after_drain();
		hold_until_drained();
		send_item(ACT_READ, 32'hFFFF_FFFF, '0);
		send_item(ACT_READ, '0, hit_log[$]);
		send_item(ACT_READ, '0, hit_log[0]);
		send_item(ACT_READ, '0, 20'h5A5A5);
		send_item(ACT_READ, '0, 20'hA5A5A);
	endtask

	task automatic test_random_mix(input int n);
		int unsigned r;
		repeat (n) begin
			r = $urandom_range(99);
			if (r < 55)
				send_item(ACT_TALLY, word_with_ones($urandom_range(14, 17)), bin_t'($urandom));
			else if (r < 72)
				send_item(ACT_TALLY, $urandom, bin_t'($urandom));
			else if (r < 78)
				send_item(ACT_TALLY, word_with_ones($urandom_range(0, 32)), '0);
			else if (hit_log.size() != 0 && $urandom_range(2) != 0)
				send_item(ACT_READ, $urandom,
					hit_log[$urandom_range(hit_log.size() - 1)]);
			else
				send_item(ACT_READ, $urandom, bin_t'($urandom));
		end
	endtask

	task automatic test_back_to_back(input int n);
		sender_idle_on = 1'b0;
		sink_stall_on  = 1'b0;
		test_random_mix(n);
		sender_idle_on = 1'b1;
		sink_stall_on  = 1'b1;
	endtask

	// receiver: stalls of random length between runs of readiness
	initial begin
		int unsigned n;
		forever begin
			n = sink_stall_on ? pick_gap() : 0;
			if (n != 0) begin
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		hist_reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (replies_q.size() == 0) begin
				$error("result transfer with no reply pending");
				errors++;
			end else begin
				want = replies_q.pop_front();
				if (m_tdata[63:0] !== want.bin_count) begin
					$error("bin_count: expected %0h, got %0h", want.bin_count, m_tdata[63:0]);
					errors++;
				end
				if (m_tuser !== want.tallied) begin
					$error("tallied: expected %0b, got %0b", want.tallied, m_tuser);
					errors++;
				end
				if (m_tdata[83:64] !== want.tally_bin) begin
					$error("tally_bin: expected %0h, got %0h", want.tally_bin, m_tdata[83:64]);
					errors++;
				end
				if (m_tdata[147:84] !== want.total_tallies) begin
					$error("total_tallies: expected %0h, got %0h", want.total_tallies,
						m_tdata[147:84]);
					errors++;
				end
			end
		end
	end

	// the timeout leaves room for the bin sweep after reset
	initial begin
		#32_000_000;
		$display("popcount_tuple_histogram verification failed");
		$finish;
	end

	initial begin
		foreach (win_nib[i])
			win_nib[i] = '0;
		win_fill    = 0;
		tally_count = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_window_fill();
		test_extreme_words();
		test_readback_after_drain();
		test_random_mix(300);
		test_back_to_back(150);
		test_random_mix(250);
		hold_until_drained();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("popcount_tuple_histogram verification clean");
		else
			$display("popcount_tuple_histogram verification failed");
		$finish;
	end

endmodule
